// ===== hdl/erg_pkg.sv =====
// shared types and constants of the euclidean rhythm generator
package erg_pkg;

  localparam int unsigned MaxSteps = 32;
  localparam int unsigned PulseW   = 7;
  localparam int unsigned StepW    = 6;
  localparam int unsigned RotW     = 16;
  localparam int unsigned WordW    = 32;
  localparam int unsigned RotCntW  = $clog2(RotW);

  typedef logic [WordW-1:0] word_t;
  typedef logic [StepW-1:0] cnt_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic fold_step;
    logic cat_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic mod_last;
    logic fold_more;
    logic cat_done;
  } status_t;

endpackage

// ===== hdl/erg_if.sv =====
// request and response channel interfaces
interface erg_req_if;
  import erg_pkg::*;
  logic                valid;
  logic                ready;
  logic [PulseW-1:0]   pulse_count;
  logic [StepW-1:0]    step_count;
  logic [RotW-1:0]     rotate_by;

  modport source (output valid, pulse_count, step_count, rotate_by, input ready);
  modport sink (input valid, pulse_count, step_count, rotate_by, output ready);
endinterface

interface erg_rsp_if;
  import erg_pkg::*;
  logic              valid;
  logic              ready;
  logic              valid_res;
  logic [WordW-1:0]  rhythm_bits;

  modport source (output valid, valid_res, rhythm_bits, input ready);
  modport sink (input valid, valid_res, rhythm_bits, output ready);
endinterface

// ===== hdl/euclidean_rhythm_generator.sv =====
// Euclidean rhythm generator: one request (pulse count, step count, rotation)
// gives one transfer of a rhythm word, bit i being step i, built by folding
// groups of ones and zeros. An accepted request runs the bit-serial rotation
// modulo, then the fold rounds, then lays out the word group by group, and
// last inverts and rotates it. A step count of zero or above 32 returns in
// the cycle after acceptance with valid_res low and a zero word. One request
// is in flight at a time; the next is taken after the result transfer.
module euclidean_rhythm_generator (
  input logic       clk_i,
  input logic       rst_ni,
  erg_req_if.sink   req_i,
  erg_rsp_if.source rsp_o
);
  import erg_pkg::*;

  cmd_t    cmd;
  status_t status;

  erg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  erg_dp u_dp (
    .clk_i         (clk_i),
    .pulse_count_i (req_i.pulse_count),
    .step_count_i  (req_i.step_count),
    .rotate_by_i   (req_i.rotate_by),
    .cmd_i         (cmd),
    .status_o      (status),
    .valid_res_o   (rsp_o.valid_res),
    .rhythm_bits_o (rsp_o.rhythm_bits)
  );

endmodule

// ===== hdl/erg_ctrl.sv =====
// sequencing state machine of the rhythm generator
module erg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  erg_pkg::status_t status_i,
  output erg_pkg::cmd_t    cmd_o
);
  import erg_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_FOLD = 3'd2;
  localparam logic [2:0] S_CAT  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.bad ? S_OUT : S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) state_d = S_FOLD;
      end
      S_FOLD: begin
        if (status_i.fold_more) cmd_o.fold_step = 1'b1;
        else state_d = S_CAT;
      end
      S_CAT: begin
        if (status_i.cat_done) state_d = S_FIN;
        else cmd_o.cat_step = 1'b1;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/erg_dp.sv =====
// datapath: rotation modulo, group folding, concatenation and final invert and rotate
module erg_dp (
  input  logic                       clk_i,
  input  logic [erg_pkg::PulseW-1:0] pulse_count_i,
  input  logic [erg_pkg::StepW-1:0]  step_count_i,
  input  logic [erg_pkg::RotW-1:0]   rotate_by_i,
  input  erg_pkg::cmd_t              cmd_i,
  output erg_pkg::status_t           status_o,
  output logic                       valid_res_o,
  output logic [erg_pkg::WordW-1:0]  rhythm_bits_o
);
  import erg_pkg::*;

  cnt_t               n_q, xn_q, yn_q, la_q, lb_q, pos_q, rem_q;
  word_t              a_q, b_q, acc_q, res_q;
  logic               inv_q, rneg_q, vres_q;
  logic [RotW-1:0]    rmag_q;
  logic [RotCntW-1:0] rcnt_q;

  logic [PulseW-1:0]  mag;
  cnt_t               ons, keep, rest, rot_r;
  logic [StepW:0]     trial;
  word_t              mask, w_inv, w_rot;

  // load-time decode
  always_comb begin
    mag = pulse_count_i[PulseW-1] ? PulseW'(-pulse_count_i) : pulse_count_i;
    ons = (mag > PulseW'(step_count_i)) ? step_count_i : StepW'(mag);
  end

  assign status_o.bad = (step_count_i == '0) ||
                        ({1'b0, step_count_i} > (StepW+1)'(MaxSteps));
  assign status_o.mod_last  = (rcnt_q == RotCntW'(RotW-1));
  assign keep               = (xn_q < yn_q) ? xn_q : yn_q;
  assign rest               = (xn_q > yn_q) ? xn_q - yn_q : yn_q - xn_q;
  assign status_o.fold_more = (keep > StepW'(1));
  assign status_o.cat_done  = (xn_q == '0) && (yn_q == '0);

  assign trial = {rem_q, rmag_q[RotW-1]};

  always_comb begin
    mask  = (n_q >= StepW'(WordW)) ? '1 : ((WordW'(1) << n_q) - WordW'(1));
    w_inv = (inv_q ? ~acc_q : acc_q) & mask;
    rot_r = (rneg_q && rem_q != '0) ? n_q - rem_q : rem_q;
    w_rot = ((w_inv << rot_r) | (w_inv >> (n_q - rot_r))) & mask;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q    <= step_count_i;
      inv_q  <= pulse_count_i[PulseW-1];
      rneg_q <= rotate_by_i[RotW-1];
      rmag_q <= rotate_by_i[RotW-1] ? RotW'(-rotate_by_i) : rotate_by_i;
      rem_q  <= '0;
      rcnt_q <= '0;
      xn_q   <= ons;
      yn_q   <= step_count_i - ons;
      a_q    <= WordW'(1);
      b_q    <= '0;
      la_q   <= StepW'(1);
      lb_q   <= StepW'(1);
      acc_q  <= '0;
      pos_q  <= '0;
      res_q  <= '0;
      vres_q <= ~status_o.bad;
    end
    if (cmd_i.mod_step) begin
      rem_q  <= (trial >= {1'b0, n_q}) ? StepW'(trial - {1'b0, n_q}) : StepW'(trial);
      rmag_q <= rmag_q << 1;
      rcnt_q <= rcnt_q + RotCntW'(1);
    end
    if (cmd_i.fold_step) begin
      a_q  <= a_q | (b_q << la_q);
      la_q <= la_q + lb_q;
      yn_q <= rest;
      if (xn_q > yn_q) begin
        b_q  <= a_q;
        lb_q <= la_q;
        xn_q <= keep;
      end
    end
    if (cmd_i.cat_step) begin
      if (xn_q != '0) begin
        acc_q <= acc_q | (a_q << pos_q);
        pos_q <= pos_q + la_q;
        xn_q  <= xn_q - StepW'(1);
      end else begin
        acc_q <= acc_q | (b_q << pos_q);
        pos_q <= pos_q + lb_q;
        yn_q  <= yn_q - StepW'(1);
      end
    end
    if (cmd_i.finish) begin
      res_q <= w_rot;
    end
  end

  assign valid_res_o   = vres_q;
  assign rhythm_bits_o = res_q;

endmodule

// ===== bench/tb_euclidean_rhythm_generator.sv =====
// self-checking testbench of the euclidean rhythm generator
module tb_euclidean_rhythm_generator;
  import erg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [PulseW-1:0] pulses;
    logic [StepW-1:0]         steps;
    logic signed [RotW-1:0]   rot;
    logic                     has_exp;
    logic                     exp_valid;
    word_t                    exp_word;
  } req_row_t;

  typedef struct {
    logic  ok;
    word_t word;
  } rhythm_t;

  localparam int unsigned WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  erg_req_if req_if ();
  erg_rsp_if rsp_if ();

  euclidean_rhythm_generator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  rhythm_t rhythm_q[$];
  int      n_fail = 0;
  int      n_reqs = 0;
  int      n_rsps = 0;
  int      n_bad_steps = 0;
  int      send_idle = 18;
  int      recv_idle = 50;
  bit      hold_off = 1'b0;
  int      quiet_cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // bjorklund folding on two group lists, then inversion and rotation
  function automatic rhythm_t predict_rhythm(logic signed [PulseW-1:0] pulses,
                                             logic [StepW-1:0] steps,
                                             logic signed [RotW-1:0] rot);
    rhythm_t    res;
    logic [63:0] ones_w[MaxSteps];
    logic [63:0] zero_w[MaxSteps];
    int         ones_l[MaxSteps];
    int         zero_l[MaxSteps];
    int         n, ons, xn, yn, keep, rest, pos, r;
    bit         inv;
    logic [63:0] word, mask;
    n = int'(steps);
    res.ok = 1'b0;
    res.word = '0;
    if (n == 0 || n > MaxSteps) return res;
    inv = pulses < 0;
    ons = inv ? -int'(pulses) : int'(pulses);
    if (ons > n) ons = n;
    xn = ons;
    yn = n - ons;
    for (int i = 0; i < xn; i++) begin ones_w[i] = 64'd1; ones_l[i] = 1; end
    for (int i = 0; i < yn; i++) begin zero_w[i] = 64'd0; zero_l[i] = 1; end
    while ((xn < yn ? xn : yn) > 1) begin
      keep = xn < yn ? xn : yn;
      rest = xn > yn ? xn - yn : yn - xn;
      for (int i = 0; i < keep; i++) begin
        if (ones_l[i] < 64) ones_w[i] |= zero_w[i] << ones_l[i];
        ones_l[i] += zero_l[i];
      end
      if (xn > yn) begin
        for (int i = 0; i < rest; i++) begin
          zero_w[i] = ones_w[keep+i];
          zero_l[i] = ones_l[keep+i];
        end
        xn = keep;
      end else begin
        for (int i = 0; i < rest; i++) begin
          zero_w[i] = zero_w[keep+i];
          zero_l[i] = zero_l[keep+i];
        end
      end
      yn = rest;
    end
    word = '0;
    pos = 0;
    for (int g = 0; g < xn; g++) begin
      if (pos < 64) word |= ones_w[g] << pos;
      pos += ones_l[g];
    end
    for (int g = 0; g < yn; g++) begin
      if (pos < 64) word |= zero_w[g] << pos;
      pos += zero_l[g];
    end
    mask = (64'd1 << n) - 64'd1;
    word &= mask;
    if (inv) word = ~word & mask;
    r = int'(rot) % n;
    if (r < 0) r += n;
    if (r != 0) word = ((word << r) | (word >> (n - r))) & mask;
    res.ok = 1'b1;
    res.word = word[31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch in %s at %0t: got %h, want %h", what, $time, got, want);
    n_fail++;
  endtask

  task automatic send_rhythm_req(req_row_t row);
    rhythm_t exp;
    if ($urandom_range(99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.pulse_count <= row.pulses;
    req_if.step_count  <= row.steps;
    req_if.rotate_by   <= row.rot;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    exp = predict_rhythm(row.pulses, row.steps, row.rot);
    if (row.has_exp) begin
      exp.ok = row.exp_valid;
      exp.word = row.exp_word;
    end
    rhythm_q.push_back(exp);
    n_reqs++;
    if (row.steps == 0 || row.steps > MaxSteps) n_bad_steps++;
  endtask

  function automatic req_row_t mk_row(int p, int s, int r, bit he, bit ev, word_t ew);
    req_row_t row;
    row.pulses = PulseW'(p);
    row.steps = StepW'(s);
    row.rot = RotW'(r);
    row.has_exp = he;
    row.exp_valid = ev;
    row.exp_word = ew;
    return row;
  endfunction

  function automatic req_row_t rand_row();
    int s;
    s = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(1, MaxSteps);
    return mk_row($urandom_range(127) - 64, s, $urandom_range(65535) - 32768,
                  1'b0, 1'b0, '0);
  endfunction

  // response side
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        if (rhythm_q.size() == 0) begin
          report_mismatch("unexpected transfer", rsp_if.rhythm_bits, 32'd0);
        end else begin
          if (rsp_if.valid_res !== rhythm_q[0].ok)
            report_mismatch("valid_res", 32'(rsp_if.valid_res), 32'(rhythm_q[0].ok));
          if (rsp_if.rhythm_bits !== rhythm_q[0].word)
            report_mismatch("rhythm_bits", rsp_if.rhythm_bits, rhythm_q[0].word);
          void'(rhythm_q.pop_front());
        end
        n_rsps++;
      end
      rsp_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  // long receiver hold-off while requests keep coming
  initial begin
    wait (n_reqs == 100);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("watchdog expired after %0d idle cycles", quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    req_row_t dir_rows[$];
    req_if.valid = 1'b0;
    req_if.pulse_count = '0;
    req_if.step_count = '0;
    req_if.rotate_by = '0;
    dir_rows = '{
      mk_row(3, 0, 0, 1, 0, 32'h0),
      mk_row(5, 33, 7, 1, 0, 32'h0),
      mk_row(-63, 63, -1, 1, 0, 32'h0),
      mk_row(0, 1, 0, 1, 1, 32'h0),
      mk_row(1, 1, 0, 1, 1, 32'h1),
      mk_row(63, 32, 0, 1, 1, 32'hffffffff),
      mk_row(-64, 32, 5, 1, 1, 32'h0),
      mk_row(-1, 1, 0, 1, 1, 32'h0),
      mk_row(0, 32, 0, 1, 1, 32'h0),
      mk_row(-63, 7, 3, 1, 1, 32'h0),
      mk_row(40, 8, 1, 1, 1, 32'hff),
      mk_row(3, 8, 0, 0, 0, 0),
      mk_row(5, 8, 0, 0, 0, 0),
      mk_row(-3, 8, 1, 0, 0, 0),
      mk_row(7, 12, -1, 0, 0, 0),
      mk_row(13, 32, 32767, 0, 0, 0),
      mk_row(19, 32, -32768, 0, 0, 0),
      mk_row(31, 32, 1, 0, 0, 0),
      mk_row(1, 32, 31, 0, 0, 0),
      mk_row(-5, 13, -14, 0, 0, 0),
      mk_row(2, 31, 100, 0, 0, 0),
      mk_row(16, 32, -17, 0, 0, 0)
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) send_rhythm_req(dir_rows[i]);
    for (int i = 0; i < 1830; i++) begin
      if (i == 600) begin send_idle = 50; recv_idle = 18; end
      if (i == 1200) begin send_idle = 0; recv_idle = 0; end
      send_rhythm_req(rand_row());
    end
    req_if.valid <= 1'b0;
    while (rhythm_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("%0d requests sent, %0d responses checked, %0d with step count out of range",
             n_reqs, n_rsps, n_bad_steps);
    $display("covered clamping, inversion, signed rotation and three idle patterns");
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
